// ===== sv/mawp_pkg.sv =====
// types, constants and pulse mapping shared by the waypoint player
package mawp_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2
    } t_mawp_op;

    localparam logic [7:0]  ANGLE_MAX   = 8'd180;
    localparam logic [7:0]  ANGLE_HOME  = 8'd90;
    localparam logic [9:0]  PULSE_MIN   = 10'd115;
    localparam logic [9:0]  PULSE_MAX   = 10'd530;
    // floor(v * 415 / 180) as a reciprocal multiply, exact for v up to 180
    localparam logic [28:0] PULSE_MUL   = 29'd1208812;
    localparam int          PULSE_SHIFT = 19;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] load_index;
        logic [7:0] target_0;
        logic [7:0] target_1;
        logic [7:0] target_2;
        logic [7:0] target_3;
        logic [7:0] pump_level;
        logic [7:0] valve_level;
    } t_mawp_in;

    typedef struct packed {
        logic [9:0] pulse_0;
        logic [9:0] pulse_1;
        logic [9:0] pulse_2;
        logic [9:0] pulse_3;
        logic [9:0] pulse_pump;
        logic [9:0] pulse_valve;
        logic [5:0] step_index;
        logic       sequence_done;
        logic       waypoint_reached;
    } t_mawp_out;

    typedef struct packed {
        logic [3:0][7:0] axis;
        logic [7:0]      pump;
        logic [7:0]      valve;
    } t_mawp_entry;

    function automatic logic [7:0] sat180(input logic [7:0] v);
        return (v > ANGLE_MAX) ? ANGLE_MAX : v;
    endfunction

    function automatic logic [7:0] invert(input logic [7:0] v);
        return ANGLE_MAX - sat180(v);
    endfunction

    function automatic logic [9:0] pulse_of(input logic [7:0] v);
        logic [28:0] prod;
        prod = 29'(sat180(v)) * PULSE_MUL;
        return PULSE_MIN + 10'(prod >> PULSE_SHIFT);
    endfunction

endpackage

// ===== sv/mawp_table.sv =====
// waypoint table memory with registered read and write-to-read forwarding
module mawp_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  mawp_pkg::t_mawp_entry    i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output mawp_pkg::t_mawp_entry    o_rdata
);
    import mawp_pkg::*;

    t_mawp_entry r_mem [DEPTH];
    t_mawp_entry r_rd;
    t_mawp_entry r_fwd_data;
    logic        r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd       <= r_mem[i_raddr];
        r_fwd      <= i_we && (i_waddr == i_raddr);
        r_fwd_data <= i_wdata;
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rd;

endmodule

// ===== sv/multi_axis_waypoint_player_core.sv =====
// waypoint player top level: state update, result stage and output register
// result: the accepted transaction passes the result stage, then the output register
// throughput: one transaction per clock unless the output stalls; the table entry
// at the play index is read ahead from the synchronous memory, with load forwarding
// reset: synchronous, active low; angles home to 90, levels 0, arrived flags
// set, play index 0, step count 0; table contents undefined until loaded
module multi_axis_waypoint_player_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mawp_pkg::t_mawp_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mawp_pkg::t_mawp_out  o_out_data
);
    import mawp_pkg::*;

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW_A = $clog2(TABLE_DEPTH + 1);
    localparam int CW   = (CW_A > 6) ? CW_A : 6;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [3:0][7:0] r_angle, n_angle;
    logic [3:0]      r_arrived, n_arrived;
    logic [7:0]      r_pump, n_pump;
    logic [7:0]      r_valve, n_valve;
    logic [5:0]      r_play, n_play;
    logic [5:0]      r_step_count;
    logic            r_s1_valid;
    logic            r_s1_reached;
    logic            n_reached;
    logic            r_out_valid;
    t_mawp_out       r_out_data;
    t_mawp_out       n_out_data;

    logic            accept;
    logic            s1_adv;
    logic            active;
    logic            load_ok;
    logic [CW-1:0]   play_ext;
    logic [CW-1:0]   n_play_ext;
    logic [CW-1:0]   load_ext;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   waddr;
    logic            we;
    t_mawp_entry     wdata;
    t_mawp_entry     entry;

    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign s1_adv     = r_s1_valid && !(r_out_valid && i_out_stall);

    assign play_ext = CW'(r_play);
    assign active   = (play_ext < CW'(r_step_count)) && (play_ext < DEPTH_C);
    assign load_ext = CW'(i_in_data.load_index);
    assign load_ok  = load_ext < DEPTH_C;
    assign waddr    = load_ext[AW-1:0];
    assign we       = accept && (i_in_data.op == OP_LOAD) && load_ok;

    assign wdata.axis[0] = sat180(i_in_data.target_0);
    assign wdata.axis[1] = sat180(i_in_data.target_1);
    assign wdata.axis[2] = sat180(i_in_data.target_2);
    assign wdata.axis[3] = sat180(i_in_data.target_3);
    assign wdata.pump    = sat180(i_in_data.pump_level);
    assign wdata.valve   = sat180(i_in_data.valve_level);

    assign n_play_ext = CW'(n_play);
    assign raddr      = n_play_ext[AW-1:0];

    mawp_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (entry)
    );

    always_comb begin
        n_angle   = r_angle;
        n_arrived = r_arrived;
        n_pump    = r_pump;
        n_valve   = r_valve;
        n_play    = r_play;
        n_reached = 1'b0;
        if (accept) begin
            case (i_in_data.op)
                OP_TICK: begin
                    if (active) begin
                        for (int k = 0; k < 4; k++) begin
                            if (r_angle[k] > entry.axis[k]) begin
                                n_angle[k]   = r_angle[k] - 8'd1;
                                n_arrived[k] = 1'b0;
                            end else if (r_angle[k] < entry.axis[k]) begin
                                n_angle[k]   = r_angle[k] + 8'd1;
                                n_arrived[k] = 1'b0;
                            end else begin
                                n_arrived[k] = 1'b1;
                            end
                        end
                        n_pump  = entry.pump;
                        n_valve = entry.valve;
                        if (&n_arrived) begin
                            n_arrived = '0;
                            n_play    = r_play + 6'd1;
                            n_reached = 1'b1;
                        end
                    end
                end
                OP_RESTART: begin
                    n_play = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result from the state as left by the item in the result stage
    always_comb begin
        n_out_data.pulse_0          = pulse_of(r_angle[0]);
        n_out_data.pulse_1          = pulse_of(r_angle[1]);
        n_out_data.pulse_2          = pulse_of(invert(r_angle[2]));
        n_out_data.pulse_3          = pulse_of(invert(r_angle[3]));
        n_out_data.pulse_pump       = pulse_of(r_pump);
        n_out_data.pulse_valve      = pulse_of(r_valve);
        n_out_data.step_index       = r_play;
        n_out_data.sequence_done    = !active;
        n_out_data.waypoint_reached = r_s1_reached;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle      <= {4{ANGLE_HOME}};
            r_arrived    <= '1;
            r_pump       <= '0;
            r_valve      <= '0;
            r_play       <= '0;
            r_step_count <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_angle   <= n_angle;
            r_arrived <= n_arrived;
            r_pump    <= n_pump;
            r_valve   <= n_valve;
            r_play    <= n_play;
            if (i_cfg_we) begin
                r_step_count <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_reached <= n_reached;
        end
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_reached_clears_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_reached |-> r_arrived == '0)
        else $error("arrived flags not cleared after waypoint reached");

    a_reached_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.waypoint_reached |-> o_out_data.step_index != '0)
        else $error("waypoint reached with index zero");

    a_stage_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !(r_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result stage did not reach output register");

    a_pulse_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pulse_0 >= PULSE_MIN && o_out_data.pulse_0 <= PULSE_MAX
            && o_out_data.pulse_pump >= PULSE_MIN && o_out_data.pulse_pump <= PULSE_MAX))
        else $error("pulse width out of range");

endmodule
